FILE: rtl/unix_seconds_to_calendar_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Unix seconds to calendar converter
// Clocked property checks that are compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef UNIX_SECONDS_TO_CALENDAR_ASSERT_SVH
`define UNIX_SECONDS_TO_CALENDAR_ASSERT_SVH

`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define USTC_ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define USTC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define USTC_ASSERT_CLK(name, prop, msg)
`define USTC_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

FILE: rtl/ustc_pkg.sv
// ----------------------------------------------------------------------------
// ustc_pkg
// Shared widths, constants, step tables and result types of the converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ustc_pkg;

  localparam int unsigned SECS_W = 38;
  localparam int unsigned DAYS_W = 22;
  localparam int unsigned TOD_W  = 17;
  localparam int unsigned YEAR_W = 14;

  localparam logic [SECS_W-1:0] LAST_SECOND  = 38'd253402300799;
  localparam logic [TOD_W-1:0]  SECS_PER_DAY = 17'd86400;
  // Days from 1601-01-01 to 1970-01-01; the walk starts at a 400-year cycle.
  localparam logic [DAYS_W-1:0] DAY_OFFSET   = 22'd134774;
  localparam logic [YEAR_W-1:0] BASE_YEAR    = 14'd1601;

  localparam logic [5:0] DIV_LAST = 6'd37;

  // Year walk step ranges
  localparam logic [3:0] STEP_CENT_LO = 4'd5;
  localparam logic [3:0] STEP_CENT_HI = 4'd6;
  localparam logic [3:0] STEP_QUAD_LO = 4'd7;
  localparam logic [3:0] STEP_QUAD_HI = 4'd11;
  localparam logic [3:0] STEP_YEAR_LO = 4'd12;
  localparam logic [3:0] STEP_YEAR_HI = 4'd13;

  // Hour/minute split step ranges
  localparam logic [3:0] STEP_HOUR_HI = 4'd4;
  localparam logic [3:0] STEP_MIN_HI  = 4'd10;

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [3:0]        month;
    logic [4:0]        day;
  } date_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } hms_t;

  // Day count subtracted at each year walk step: 400, 100, 4 and 1 year
  // cycles, each shifted down one quotient bit at a time.
  function automatic logic [DAYS_W-1:0] year_step_div(input logic [3:0] idx);
    logic [DAYS_W-1:0] v;
    case (idx)
      4'd0:    v = 22'd2337552;
      4'd1:    v = 22'd1168776;
      4'd2:    v = 22'd584388;
      4'd3:    v = 22'd292194;
      4'd4:    v = 22'd146097;
      4'd5:    v = 22'd73048;
      4'd6:    v = 22'd36524;
      4'd7:    v = 22'd23376;
      4'd8:    v = 22'd11688;
      4'd9:    v = 22'd5844;
      4'd10:   v = 22'd2922;
      4'd11:   v = 22'd1461;
      4'd12:   v = 22'd730;
      4'd13:   v = 22'd365;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [YEAR_W-1:0] year_step_yrs(input logic [3:0] idx);
    logic [YEAR_W-1:0] v;
    case (idx)
      4'd0:    v = 14'd6400;
      4'd1:    v = 14'd3200;
      4'd2:    v = 14'd1600;
      4'd3:    v = 14'd800;
      4'd4:    v = 14'd400;
      4'd5:    v = 14'd200;
      4'd6:    v = 14'd100;
      4'd7:    v = 14'd64;
      4'd8:    v = 14'd32;
      4'd9:    v = 14'd16;
      4'd10:   v = 14'd8;
      4'd11:   v = 14'd4;
      4'd12:   v = 14'd2;
      4'd13:   v = 14'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Seconds subtracted at each hour and minute quotient bit.
  function automatic logic [TOD_W-1:0] hms_step_div(input logic [3:0] idx);
    logic [TOD_W-1:0] v;
    case (idx)
      4'd0:    v = 17'd57600;
      4'd1:    v = 17'd28800;
      4'd2:    v = 17'd14400;
      4'd3:    v = 17'd7200;
      4'd4:    v = 17'd3600;
      4'd5:    v = 17'd1920;
      4'd6:    v = 17'd960;
      4'd7:    v = 17'd480;
      4'd8:    v = 17'd240;
      4'd9:    v = 17'd120;
      4'd10:   v = 17'd60;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
    logic [4:0] v;
    case (month) inside
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: v = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    v = 5'd30;
      4'd2:                                       v = leap ? 5'd29 : 5'd28;
      default:                                    v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/unix_seconds_to_calendar.sv
// ----------------------------------------------------------------------------
// unix_seconds_to_calendar
// Flow from accepted word to result valid: a serial divide by 86400, a
// hand-off, a 14-step year walk, a walk through the months (1 to 12),
// then a collect step and the load of the output register.
// One word at a time: the next word is taken once the result sits in the
// output register, which waits out any output stall. Reset clears all
// control and valids.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module unix_seconds_to_calendar import ustc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [37:0] epoch_seconds
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [13:0] year, [17:14] month,
                                      // [22:18] day_of_month, [27:23] hour,
                                      // [33:28] minute, [39:34] second
  output logic        m_axis_tuser    // [0] not_set
);

  `include "unix_seconds_to_calendar_assert.svh"

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DAY  = 4'b0010,
    ST_CAL  = 4'b0100,
    ST_HOLD = 4'b1000
  } top_state_e;

  top_state_e        state_q, state_d;
  logic              zero_q, zero_d;
  logic              date_seen_q, date_seen_d;
  logic              hms_seen_q, hms_seen_d;
  logic              out_valid_q, out_valid_d;
  logic              out_zero_q;
  date_t             out_date_q;
  hms_t              out_hms_q;

  logic [SECS_W-1:0] secs_in, secs_clamp;
  logic              accept, load;
  logic              day_done, date_done, hms_done;
  logic [DAYS_W-1:0] days;
  logic [TOD_W-1:0]  tod;
  date_t             date;
  hms_t              hms;

  assign secs_in    = s_axis_tdata[SECS_W-1:0];
  assign secs_clamp = (secs_in > LAST_SECOND) ? LAST_SECOND : secs_in;
  assign accept     = s_axis_tvalid && s_axis_tready;
  assign load       = (state_q == ST_HOLD) && (!out_valid_q || m_axis_tready);

  ustc_day_div u_day_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .secs_i  (secs_clamp),
    .done_o  (day_done),
    .days_o  (days),
    .tod_o   (tod)
  );

  ustc_date_walk u_date_walk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (day_done),
    .days_i  (days),
    .done_o  (date_done),
    .date_o  (date)
  );

  ustc_hms_split u_hms_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (day_done),
    .tod_i   (tod),
    .done_o  (hms_done),
    .hms_o   (hms)
  );

  always_comb begin
    state_d     = state_q;
    zero_d      = zero_q;
    date_seen_d = date_seen_q;
    hms_seen_d  = hms_seen_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          zero_d  = (secs_in == '0);
          state_d = ST_DAY;
        end
      end
      ST_DAY: begin
        if (day_done) begin
          date_seen_d = 1'b0;
          hms_seen_d  = 1'b0;
          state_d     = ST_CAL;
        end
      end
      ST_CAL: begin
        date_seen_d = date_seen_q || date_done;
        hms_seen_d  = hms_seen_q || hms_done;
        if (date_seen_d && hms_seen_d) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        // wait for the output register to free up
        if (load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      zero_q      <= 1'b0;
      date_seen_q <= 1'b0;
      hms_seen_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      zero_q      <= zero_d;
      date_seen_q <= date_seen_d;
      hms_seen_q  <= hms_seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_zero_q <= zero_q;
      out_date_q <= zero_q ? '0 : date;
      out_hms_q  <= zero_q ? '0 : hms;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_zero_q;
  assign m_axis_tdata  = {out_hms_q.second, out_hms_q.minute, out_hms_q.hour,
                          out_date_q.day, out_date_q.month, out_date_q.year};

  `USTC_ASSERT_CLK(a_busy_after_accept, accept |=> !s_axis_tready,
                   "ready high right after accept")
  `USTC_ASSERT_CLK(a_not_set_zero,
                   (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0),
                   "not-set word carries nonzero fields")
  `USTC_ASSERT_CLK(a_date_range,
                   (m_axis_tvalid && !m_axis_tuser) |->
                   (out_date_q.month != 4'd0 && out_date_q.month <= 4'd12 &&
                    out_date_q.day != 5'd0 && out_hms_q.hour <= 5'd23),
                   "calendar field out of range")
  `USTC_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !m_axis_tvalid, "output valid after reset")

endmodule

FILE: rtl/ustc_day_div.sv
// ----------------------------------------------------------------------------
// ustc_day_div
// Bit-serial restoring divide of the seconds count by 86400: whole days
// and seconds of the day, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ustc_day_div import ustc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SECS_W-1:0] secs_i,
  output logic              done_o,
  output logic [DAYS_W-1:0] days_o,
  output logic [TOD_W-1:0]  tod_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [5:0]        cnt_q, cnt_d;
  logic [SECS_W-1:0] sh_q, sh_d;
  logic [TOD_W-1:0]  rem_q, rem_d;
  logic [TOD_W:0]    trial, diff;
  logic              ge;

  assign trial = {rem_q, sh_q[SECS_W-1]};
  assign ge    = trial >= {1'b0, SECS_PER_DAY};
  assign diff  = trial - {1'b0, SECS_PER_DAY};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    if (busy_q) begin
      // quotient bits shift in behind the dividend
      rem_d = ge ? diff[TOD_W-1:0] : trial[TOD_W-1:0];
      sh_d  = {sh_q[SECS_W-2:0], ge};
      if (cnt_q == DIV_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 6'd1;
      end
    end else if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      sh_d   = secs_i;
      rem_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign days_o = sh_q[DAYS_W-1:0];
  assign tod_o  = rem_q;

endmodule

FILE: rtl/ustc_hms_split.sv
// ----------------------------------------------------------------------------
// ustc_hms_split
// Splits seconds of the day into hour, minute and second with a
// bit-serial divide by 3600 and then by 60.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ustc_hms_split import ustc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [TOD_W-1:0] tod_i,
  output logic             done_o,
  output hms_t             hms_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [3:0]       step_q, step_d;
  logic [TOD_W-1:0] r_q, r_d;
  logic [4:0]       hour_q, hour_d;
  logic [5:0]       min_q, min_d;
  logic [TOD_W-1:0] div;
  logic             ge;

  assign div = hms_step_div(step_q);
  assign ge  = r_q >= div;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    r_d    = r_q;
    hour_d = hour_q;
    min_d  = min_q;
    if (busy_q) begin
      if (ge) begin
        r_d = r_q - div;
      end
      if (step_q <= STEP_HOUR_HI) begin
        hour_d = {hour_q[3:0], ge};
      end else begin
        min_d = {min_q[4:0], ge};
      end
      if (step_q == STEP_MIN_HI) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q + 4'd1;
      end
    end else if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      r_d    = tod_i;
      hour_d = '0;
      min_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q    <= r_d;
    hour_q <= hour_d;
    min_q  <= min_d;
  end

  assign done_o       = done_q;
  assign hms_o.hour   = hour_q;
  assign hms_o.minute = min_q;
  assign hms_o.second = r_q[5:0];

endmodule

FILE: rtl/ustc_date_walk.sv
// ----------------------------------------------------------------------------
// ustc_date_walk
// Walks a day count down through 400, 100, 4 and 1 year cycles, one
// quotient bit per cycle, then through the months one per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ustc_date_walk import ustc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DAYS_W-1:0] days_i,
  output logic              done_o,
  output date_t             date_o
);

  typedef enum logic [2:0] {
    W_IDLE  = 3'b001,
    W_YEAR  = 3'b010,
    W_MONTH = 3'b100
  } walk_state_e;

  walk_state_e       state_q, state_d;
  logic              done_q, done_d;
  logic [3:0]        step_q, step_d;
  logic [DAYS_W-1:0] r_q, r_d;
  logic [YEAR_W-1:0] year_q, year_d;
  logic [1:0]        cent_q, cent_d;
  logic [4:0]        quad_q, quad_d;
  logic [1:0]        yr_q, yr_d;
  logic [3:0]        month_q, month_d;
  logic [4:0]        day_q, day_d;

  logic [DAYS_W-1:0] div;
  logic              ge;
  logic              leap;
  logic [DAYS_W-1:0] md_ext;
  logic              fits;

  assign div    = year_step_div(step_q);
  assign ge     = r_q >= div;
  // Last year of a 4-year group is leap, except a century year outside
  // the last century of the 400-year cycle.
  assign leap   = (yr_q == 2'd3) && ((quad_q != 5'd24) || (cent_q == 2'd3));
  assign md_ext = {{(DAYS_W-5){1'b0}}, month_days(month_q, leap)};
  assign fits   = r_q < md_ext;

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    step_d  = step_q;
    r_d     = r_q;
    year_d  = year_q;
    cent_d  = cent_q;
    quad_d  = quad_q;
    yr_d    = yr_q;
    month_d = month_q;
    day_d   = day_q;
    case (state_q)
      W_IDLE: begin
        if (start_i) begin
          r_d     = days_i + DAY_OFFSET;
          year_d  = BASE_YEAR;
          step_d  = '0;
          cent_d  = '0;
          quad_d  = '0;
          yr_d    = '0;
          state_d = W_YEAR;
        end
      end
      W_YEAR: begin
        if (ge) begin
          r_d    = r_q - div;
          year_d = year_q + year_step_yrs(step_q);
        end
        case (step_q) inside
          [STEP_CENT_LO:STEP_CENT_HI]: cent_d = {cent_q[0], ge};
          [STEP_QUAD_LO:STEP_QUAD_HI]: quad_d = {quad_q[3:0], ge};
          [STEP_YEAR_LO:STEP_YEAR_HI]: yr_d   = {yr_q[0], ge};
          default: ;
        endcase
        if (step_q == STEP_YEAR_HI) begin
          month_d = 4'd1;
          state_d = W_MONTH;
        end else begin
          step_d = step_q + 4'd1;
        end
      end
      W_MONTH: begin
        if (fits) begin
          day_d   = r_q[4:0] + 5'd1;
          done_d  = 1'b1;
          state_d = W_IDLE;
        end else begin
          r_d     = r_q - md_ext;
          month_d = month_q + 4'd1;
        end
      end
      default: state_d = W_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      done_q  <= 1'b0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q     <= r_d;
    year_q  <= year_d;
    cent_q  <= cent_d;
    quad_q  <= quad_d;
    yr_q    <= yr_d;
    month_q <= month_d;
    day_q   <= day_d;
  end

  assign done_o       = done_q;
  assign date_o.year  = year_q;
  assign date_o.month = month_q;
  assign date_o.day   = day_q;

endmodule
